// ----- hw/rtl/ppmfd_pkg.sv -----
`timescale 1ns / 1ps

package ppmfd_pkg;

    localparam int TICK_W     = 16;
    localparam int SCALE_W    = 24;
    localparam int PROD_W     = TICK_W + SCALE_W;
    localparam int US_W       = 11;
    localparam int CH_IDX_W   = 3;
    localparam int CH_CNT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [US_W-1:0] US_MIN = 11'd1000;
    localparam logic [US_W-1:0] US_MAX = 11'd2000;

    localparam logic [TICK_W-1:0]  LOW_GAP_RST  = 16'd900;
    localparam logic [TICK_W-1:0]  HIGH_GAP_RST = 16'd2100;
    localparam logic [SCALE_W-1:0] SCALE_RST    = 24'd65536;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_GAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_READ,
        S_MUL,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic mem_rd;
        logic mul;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic start_emit;
        logic last_chan;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hw/rtl/ppmfd_ctrl.sv -----
`timescale 1ns / 1ps

module ppmfd_ctrl
    import ppmfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                o_cmd.commit = 1'b1;
                n_state      = i_status.start_emit ? S_READ : S_IDLE;
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                // hold until the output register can take the channel
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = i_status.last_chan ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ppmfd_datapath.sv -----
`timescale 1ns / 1ps

module ppmfd_datapath
    import ppmfd_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [TICK_W-1:0]     i_capture_time,
    input  logic                  i_reader_busy,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [CH_IDX_W-1:0]   o_channel_index,
    output logic [US_W-1:0]       o_channel_us,
    output logic [CH_CNT_W-1:0]   o_channel_count,
    output logic                  o_last_in_frame
);

    localparam int SLOT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [TICK_W-1:0]  r_low_gap;
    logic [TICK_W-1:0]  r_high_gap;
    logic [SCALE_W-1:0] r_scale;

    logic [TICK_W-1:0]  r_prev;
    logic [TICK_W-1:0]  r_now;
    logic               r_busy;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_frame_channels;
    logic [SLOT_W-1:0]  r_emit;

    logic [TICK_W-1:0]  r_pulse_mem [MAX_CHANNELS];
    logic [TICK_W-1:0]  r_rd_data;
    logic [PROD_W-1:0]  r_prod;

    logic               r_out_valid;
    logic [CH_IDX_W-1:0] r_out_index;
    logic [US_W-1:0]    r_out_us;
    logic [CH_CNT_W-1:0] r_out_count;
    logic               r_out_last;

    logic [TICK_W-1:0]  w_gap;
    logic               w_is_pulse;
    logic               w_slot_free;
    logic [SLOT_W-1:0]  w_emit_inc;
    logic [PROD_W-TICK_W-1:0] w_us_raw;
    logic [US_W-1:0]    w_us;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_gap  <= LOW_GAP_RST;
            r_high_gap <= HIGH_GAP_RST;
            r_scale    <= SCALE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOW_GAP:  r_low_gap  <= i_cfg_data[TICK_W-1:0];
                CFG_HIGH_GAP: r_high_gap <= i_cfg_data[TICK_W-1:0];
                CFG_SCALE:    r_scale    <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // wraps modulo 2^16
    assign w_gap       = r_now - r_prev;
    assign w_is_pulse  = (w_gap > r_low_gap) && (w_gap < r_high_gap);
    assign w_slot_free = r_slot < SLOT_W'(MAX_CHANNELS);
    assign w_emit_inc  = r_emit + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now  <= i_capture_time;
            r_busy <= i_reader_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev           <= '0;
            r_slot           <= '0;
            r_frame_channels <= '0;
            r_emit           <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_prev <= r_now;
                r_emit <= '0;
                if (w_is_pulse) begin
                    if (w_slot_free) begin
                        r_slot <= r_slot + SLOT_W'(1);
                    end
                end else begin
                    if (r_slot != '0) begin
                        r_frame_channels <= r_slot;
                    end
                    r_slot <= '0;
                end
            end
            if (i_cmd.push) begin
                r_emit <= w_emit_inc;
            end
        end
    end

    // pulse store: one write port at commit, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_is_pulse && w_slot_free) begin
            r_pulse_mem[r_slot[IDX_W-1:0]] <= w_gap;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_pulse_mem[r_emit[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_rd_data) * PROD_W'(r_scale);
        end
    end

    assign w_us_raw = r_prod[PROD_W-1:TICK_W];

    always_comb begin
        if (w_us_raw < (PROD_W-TICK_W)'(US_MIN)) begin
            w_us = US_MIN;
        end else if (w_us_raw > (PROD_W-TICK_W)'(US_MAX)) begin
            w_us = US_MAX;
        end else begin
            w_us = w_us_raw[US_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_index <= CH_IDX_W'(r_emit);
            r_out_us    <= w_us;
            r_out_count <= CH_CNT_W'(r_frame_channels);
            r_out_last  <= (w_emit_inc == r_frame_channels);
        end
    end

    assign o_status.start_emit = !w_is_pulse && (r_slot != '0) && !r_busy;
    assign o_status.last_chan  = (w_emit_inc == r_frame_channels);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_us    = r_out_us;
    assign o_channel_count = r_out_count;
    assign o_last_in_frame = r_out_last;

endmodule

// ----- hw/rtl/ppm_frame_decoder_unit.sv -----
`timescale 1ns / 1ps

// PPM frame decoder.
// Input channel (i_in_valid / o_in_stall): one timer capture per transfer,
// with the reader-busy flag. Gaps inside the configured tick window are
// channel pulses; any other gap is a sync that closes the frame.
// Output channel (o_out_valid / i_out_stall): one transfer per published
// channel, in slot order, with index, width in us, count and last flag.
// Configuration: write-only port, register 0 low gap, 1 high gap,
// 2 us-per-tick in Q8.16. Write only while the block is idle.
// Sequence: each capture is loaded, then classified. A sync that
// publishes channels then passes each one through the read, multiply
// and push states in turn; a push waits for a free output register. Each
// channel goes through the shared store read, multiply and clamp steps.
// The next capture is taken as soon as the last channel sits in the
// output register, even if that channel is still waiting.
// A stall on the output holds the current channel and pauses the frame.
// Reset (synchronous, active low) restores the register defaults and
// clears the previous capture and channel counts; no clearing pass.

module ppm_frame_decoder_unit
    import ppmfd_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [TICK_W-1:0]     i_capture_time,
    input  logic                  i_reader_busy,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CH_IDX_W-1:0]   o_channel_index,
    output logic [US_W-1:0]       o_channel_us,
    output logic [CH_CNT_W-1:0]   o_channel_count,
    output logic                  o_last_in_frame
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    ppmfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    ppmfd_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_capture_time  (i_capture_time),
        .i_reader_busy   (i_reader_busy),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_channel_index (o_channel_index),
        .o_channel_us    (o_channel_us),
        .o_channel_count (o_channel_count),
        .o_last_in_frame (o_last_in_frame)
    );

    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled while a capture is processed");

    a_push_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> o_in_stall)
        else $error("channel published while input open");

    a_push_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> o_out_valid)
        else $error("published channel not presented");

    a_us_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_channel_us >= US_MIN) && (o_channel_us <= US_MAX))
        else $error("channel width outside clamp range");

endmodule
